// ===== rtl/core/whole_word_blocklist_matcher_defines.svh =====
// assertion macros used by the checker
`ifndef WHOLE_WORD_BLOCKLIST_MATCHER_DEFINES_SVH
`define WHOLE_WORD_BLOCKLIST_MATCHER_DEFINES_SVH

// same-cycle implication, quiet while reset is applied
`define WBM_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while reset is applied
`define WBM_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/wbm_pkg.sv =====
package wbm_pkg;

  // default geometry of the blocked-word store
  localparam int unsigned DefWordCount  = 32;
  localparam int unsigned DefWordLength = 16;

  // character classes
  localparam logic [7:0] CharLowA = 8'h61;  // a
  localparam logic [7:0] CharLowZ = 8'h7a;  // z
  localparam logic [7:0] CharUpA  = 8'h41;  // A
  localparam logic [7:0] CharUpZ  = 8'h5a;  // Z
  localparam logic [7:0] CharDig0 = 8'h30;  // 0
  localparam logic [7:0] CharDig9 = 8'h39;  // 9
  localparam logic [7:0] CaseBit  = 8'h20;
  localparam logic [7:0] CharNul  = 8'h00;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_TITLE = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // kind of pass over the stored words
  typedef enum logic {
    SW_TAKE,
    SW_CLOSE
  } sweep_e;

  // write strobes towards the two memories
  typedef struct packed {
    logic word;
    logic match;
  } mem_we_t;

endpackage

// ===== rtl/core/wbm_ram.sv =====
module wbm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/wbm_ctrl.sv =====
module wbm_ctrl #(
  parameter int unsigned WordCount  = 32,
  parameter int unsigned WordLength = 16,
  localparam int unsigned Depth = WordCount * WordLength,
  localparam int unsigned AW    = $clog2(Depth),
  localparam int unsigned MW    = (WordCount > 1) ? $clog2(WordCount) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            opcode_i,
  input  logic [4:0]      word_slot_i,
  input  logic [3:0]      char_position_i,
  input  logic [7:0]      char_value_i,
  input  logic            title_end_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            blocked_o,
  output wbm_pkg::mem_we_t we_o,
  output logic [AW-1:0]   wmem_wr_addr_o,
  output logic [7:0]      wmem_wr_data_o,
  output logic [AW-1:0]   wmem_rd_addr_o,
  input  logic [7:0]      wmem_rd_data_i,
  output logic [MW-1:0]   mmem_wr_addr_o,
  output logic [0:0]      mmem_wr_data_o,
  output logic [MW-1:0]   mmem_rd_addr_o,
  input  logic [0:0]      mmem_rd_data_i
);

  import wbm_pkg::*;

  localparam int unsigned CW = $clog2(WordLength);
  localparam int unsigned LW = $clog2(WordLength + 2);
  localparam logic [LW-1:0] LenFull  = LW'(WordLength);
  localparam logic [AW-1:0] RowStep  = AW'(WordLength);
  localparam logic [AW-1:0] ClrLast  = AW'(Depth - 1);
  localparam logic [AW-1:0] CountLim = AW'(WordCount);
  localparam logic [MW-1:0] IdxLast  = MW'(WordCount - 1);

  state_e          state_q, state_d;
  sweep_e          kind_q, kind_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [LW-1:0]   len_q, len_d;
  logic            found_q, found_d;
  logic            last_q, last_d;
  logic            p1_valid_q, p1_valid_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      char_q, char_d;
  logic [MW-1:0]   idx_q, idx_d;
  logic [AW-1:0]   base_q, base_d;
  logic [MW-1:0]   p1_idx_q, p1_idx_d;
  logic            out_data_q, out_data_d;

  logic            accept;
  logic            is_word;
  logic            is_upper;
  logic [7:0]      char_lc;
  logic            load_ok;
  logic [AW-1:0]   load_addr;
  logic            len_lt;
  logic [CW-1:0]   col;
  logic            take_bit;
  logic            close_hit;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    is_word  = char_value_i inside {[CharLowA:CharLowZ], [CharUpA:CharUpZ],
                                    [CharDig0:CharDig9]};
    is_upper = char_value_i inside {[CharUpA:CharUpZ]};
    char_lc  = is_upper ? (char_value_i | CaseBit) : char_value_i;
  end

  assign load_ok   = (32'(word_slot_i) < WordCount) && (32'(char_position_i) < WordLength);
  assign load_addr = AW'(32'(word_slot_i) * WordLength + 32'(char_position_i));

  assign len_lt = len_q < LenFull;
  assign col    = len_lt ? CW'(len_q) : '0;

  // per-word verdicts on the data read in the previous cycle
  assign take_bit  = mmem_rd_data_i[0] && len_lt && (wmem_rd_data_i == char_q);
  assign close_hit = mmem_rd_data_i[0] && (len_q != '0) && (len_q <= LenFull) &&
                     ((len_q == LenFull) || (wmem_rd_data_i == CharNul));

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    clr_d       = clr_q;
    len_d       = len_q;
    found_d     = found_q;
    last_d      = last_q;
    char_d      = char_q;
    idx_d       = idx_q;
    base_d      = base_q;
    p1_valid_d  = 1'b0;
    p1_idx_d    = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    we_o           = '0;
    wmem_wr_addr_o = load_addr;
    wmem_wr_data_o = char_value_i;
    wmem_rd_addr_o = base_q + AW'(col);
    mmem_wr_addr_o = p1_idx_q;
    mmem_wr_data_o = 1'b1;
    mmem_rd_addr_o = idx_q;

    // write back the verdict of the previous read
    if (p1_valid_q) begin
      we_o.match = 1'b1;
      if (kind_q == SW_TAKE) begin
        mmem_wr_data_o = take_bit;
      end else if (close_hit) begin
        found_d = 1'b1;
      end
    end

    case (state_q)
      ST_CLEAR: begin
        we_o.word      = 1'b1;
        wmem_wr_addr_o = clr_q;
        wmem_wr_data_o = CharNul;
        we_o.match     = clr_q < CountLim;
        mmem_wr_addr_o = clr_q[MW-1:0];
        mmem_wr_data_o = 1'b1;
        clr_d          = clr_q + AW'(1);
        if (clr_q == ClrLast) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_TITLE) begin
            char_d  = char_lc;
            last_d  = title_end_i;
            kind_d  = is_word ? SW_TAKE : SW_CLOSE;
            idx_d   = '0;
            base_d  = '0;
            state_d = ST_SWEEP;
          end else begin
            we_o.word = load_ok;
          end
        end
      end
      ST_SWEEP: begin
        p1_valid_d = 1'b1;
        p1_idx_d   = idx_q;
        idx_d      = idx_q + MW'(1);
        base_d     = base_q + RowStep;
        if (idx_q == IdxLast) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (kind_q == SW_TAKE) begin
          if (len_q <= LenFull) begin
            len_d = len_q + LW'(1);
          end
        end else begin
          len_d = '0;
        end
        if (last_q && (kind_q == SW_TAKE)) begin
          kind_d  = SW_CLOSE;
          idx_d   = '0;
          base_d  = '0;
          state_d = ST_SWEEP;
        end else if (last_q) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = found_q;
          found_d     = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      kind_q      <= SW_TAKE;
      clr_q       <= '0;
      len_q       <= '0;
      found_q     <= 1'b0;
      last_q      <= 1'b0;
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      clr_q       <= clr_d;
      len_q       <= len_d;
      found_q     <= found_d;
      last_q      <= last_d;
      p1_valid_q  <= p1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q     <= char_d;
    idx_q      <= idx_d;
    base_q     <= base_d;
    p1_idx_q   <= p1_idx_d;
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign blocked_o   = out_data_q;

endmodule

// ===== rtl/core/whole_word_blocklist_matcher.sv =====
// whole-word blocklist matcher: load words (opcode 0) write one byte of a stored blocked word
// at row word_slot, column char_position, a zero byte ending the word, out-of-range loads being
// dropped; title words (opcode 1) stream a title a byte at a time, letters and digits forming
// words and every other byte separating them, with title letters folded to lower case; on the
// word marked title_end one result word says whether any title word equalled a whole stored
// word. after reset the store is swept clear, one entry a cycle, during which no input word is
// taken. a load is written straight to the store and leaves the input ready for the next word.
// a title byte stalls the input while the single read port of the word store and of the
// per-word match memory are walked one stored word per cycle; a final title byte that is a
// letter or digit costs one more pass over the stored words to close the word, and every final
// byte then hands over the result, waiting while an earlier result is still uncollected. the
// result sits in an output register, so loads and new title bytes are taken while it waits.
module whole_word_blocklist_matcher #(
  parameter int unsigned WordCount  = wbm_pkg::DefWordCount,
  parameter int unsigned WordLength = wbm_pkg::DefWordLength
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       opcode_i,
  input  logic [4:0] word_slot_i,
  input  logic [3:0] char_position_i,
  input  logic [7:0] char_value_i,
  input  logic       title_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       blocked_o
);

  import wbm_pkg::*;

  // store geometry: one row of WordLength bytes per blocked word
  localparam int unsigned Depth = WordCount * WordLength;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned MW    = (WordCount > 1) ? $clog2(WordCount) : 1;

  mem_we_t        we;
  logic [AW-1:0]  wmem_wr_addr;
  logic [7:0]     wmem_wr_data;
  logic [AW-1:0]  wmem_rd_addr;
  logic [7:0]     wmem_rd_data;
  logic [MW-1:0]  mmem_wr_addr;
  logic [0:0]     mmem_wr_data;
  logic [MW-1:0]  mmem_rd_addr;
  logic [0:0]     mmem_rd_data;

  // sequencer: clearing pass, loads, the per-byte sweeps and the result register
  wbm_ctrl #(
    .WordCount  (WordCount),
    .WordLength (WordLength)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .word_slot_i     (word_slot_i),
    .char_position_i (char_position_i),
    .char_value_i    (char_value_i),
    .title_end_i     (title_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .blocked_o       (blocked_o),
    .we_o            (we),
    .wmem_wr_addr_o  (wmem_wr_addr),
    .wmem_wr_data_o  (wmem_wr_data),
    .wmem_rd_addr_o  (wmem_rd_addr),
    .wmem_rd_data_i  (wmem_rd_data),
    .mmem_wr_addr_o  (mmem_wr_addr),
    .mmem_wr_data_o  (mmem_wr_data),
    .mmem_rd_addr_o  (mmem_rd_addr),
    .mmem_rd_data_i  (mmem_rd_data)
  );

  // blocked-word bytes, row-major
  wbm_ram #(
    .Width (8),
    .Depth (Depth)
  ) u_word_mem (
    .clk_i     (clk_i),
    .wr_en_i   (we.word),
    .wr_addr_i (wmem_wr_addr),
    .wr_data_i (wmem_wr_data),
    .rd_addr_i (wmem_rd_addr),
    .rd_data_o (wmem_rd_data)
  );

  // one still-matching bit per stored word for the title word in progress;
  // read-modify-write at different words in one cycle, so no overlap on an entry
  wbm_ram #(
    .Width (1),
    .Depth (WordCount)
  ) u_match_mem (
    .clk_i     (clk_i),
    .wr_en_i   (we.match),
    .wr_addr_i (mmem_wr_addr),
    .wr_data_i (mmem_wr_data),
    .rd_addr_i (mmem_rd_addr),
    .rd_data_o (mmem_rd_data)
  );

endmodule

// ===== rtl/core/wbm_checker.sv =====
`include "whole_word_blocklist_matcher_defines.svh"

module wbm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic opcode_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic blocked_o
);

  // a waiting result is held until taken
  `WBM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(blocked_o), "result dropped or changed while stalled")

  // a title byte starts a sweep, so the input side is busy next cycle
  `WBM_ASSERT_NEXT(a_title_busy, in_valid_i && !in_stall_o && opcode_i, in_stall_o, "title word not followed by a busy input")

  // a load is a plain store write, so the input stays ready
  `WBM_ASSERT_NEXT(a_load_quick, in_valid_i && !in_stall_o && !opcode_i, !in_stall_o, "load word stalled the input")

  // a new result only comes out of a busy phase
  `WBM_ASSERT_NOW(a_result_src, $rose(out_valid_o), $past(in_stall_o), "result appeared without a sweep")

endmodule

bind whole_word_blocklist_matcher wbm_checker u_checker (.*);
